[rtl/core/uutp_pkg.sv]
`timescale 1ns / 1ps

package uutp_pkg;

    localparam int DIGIT_W = 6;
    localparam int HALF_W  = 64;

    localparam logic [DIGIT_W-1:0] DIGITS_NEEDED = 6'd32;

    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_OPEN   = 8'h7B;
    localparam logic [7:0] CH_CLOSE  = 8'h7D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [3:0] NIB_TEN   = 4'd10;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
        logic       is_hyphen;
        logic       is_open;
        logic       is_close;
    } char_class_t;

    typedef struct packed {
        logic              ok;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
    } result_t;

endpackage

[rtl/core/uutp_hex_dec.sv]
`timescale 1ns / 1ps

module uutp_hex_dec
(
    input  logic [7:0]           character,
    output uutp_pkg::char_class_t cls
);
    import uutp_pkg::*;

    logic [7:0] off_digit;
    logic [7:0] off_lower;
    logic [7:0] off_upper;

    assign off_digit = character - CH_0;
    assign off_lower = character - CH_LA;
    assign off_upper = character - CH_UA;

    always_comb
    begin
        cls.is_hyphen = (character == CH_HYPHEN);
        cls.is_open   = (character == CH_OPEN);
        cls.is_close  = (character == CH_CLOSE);
        cls.is_hex    = 1'b1;
        cls.nibble    = 4'd0;
        priority if (character >= CH_0 && character <= CH_9)
        begin
            cls.nibble = off_digit[3:0];
        end
        else if (character >= CH_LA && character <= CH_LF)
        begin
            cls.nibble = off_lower[3:0] + NIB_TEN;
        end
        else if (character >= CH_UA && character <= CH_UF)
        begin
            cls.nibble = off_upper[3:0] + NIB_TEN;
        end
        else
        begin
            cls.is_hex = 1'b0;
        end
    end

endmodule

[rtl/core/uutp_accum.sv]
`timescale 1ns / 1ps

module uutp_accum
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic                  is_last,
    input  uutp_pkg::char_class_t cls,
    output uutp_pkg::result_t     result
);
    import uutp_pkg::*;

    logic [DIGIT_W-1:0] count_reg, count_next;
    logic [HALF_W-1:0]  upper_reg, upper_next;
    logic [HALF_W-1:0]  lower_reg, lower_next;
    logic               failed_reg, failed_next;
    logic               start_reg, start_next;
    logic               brace_reg, brace_next;

    logic [DIGIT_W-1:0] count_upd;
    logic [HALF_W-1:0]  upper_upd;
    logic [HALF_W-1:0]  lower_upd;
    logic               failed_upd;
    logic               brace_upd;

    always_comb
    begin
        count_upd  = count_reg;
        upper_upd  = upper_reg;
        lower_upd  = lower_reg;
        failed_upd = failed_reg;
        brace_upd  = brace_reg;
        priority if (start_reg && !is_last && cls.is_open)
        begin
            brace_upd = 1'b1;
        end
        else if (is_last && cls.is_close && brace_reg)
        begin
            // matched closing brace
        end
        else if (cls.is_hyphen)
        begin
            // skipped
        end
        else if (!cls.is_hex || count_reg[DIGIT_W-1])
        begin
            failed_upd = 1'b1;
        end
        else
        begin
            if (count_reg[DIGIT_W-1:DIGIT_W-2] == 2'b00)
            begin
                upper_upd = {upper_reg[HALF_W-5:0], cls.nibble};
            end
            else
            begin
                lower_upd = {lower_reg[HALF_W-5:0], cls.nibble};
            end
            count_upd = count_reg + 6'd1;
        end

        result.ok = !failed_upd && (count_upd == DIGITS_NEEDED)
                    && !(brace_upd && !cls.is_close);
        result.hi = result.ok ? upper_upd : '0;
        result.lo = result.ok ? lower_upd : '0;

        count_next  = count_reg;
        upper_next  = upper_reg;
        lower_next  = lower_reg;
        failed_next = failed_reg;
        start_next  = start_reg;
        brace_next  = brace_reg;
        if (go)
        begin
            if (is_last)
            begin
                count_next  = '0;
                upper_next  = '0;
                lower_next  = '0;
                failed_next = 1'b0;
                start_next  = 1'b1;
                brace_next  = 1'b0;
            end
            else
            begin
                count_next  = count_upd;
                upper_next  = upper_upd;
                lower_next  = lower_upd;
                failed_next = failed_upd;
                start_next  = 1'b0;
                brace_next  = brace_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            upper_reg  <= '0;
            lower_reg  <= '0;
            failed_reg <= 1'b0;
            start_reg  <= 1'b1;
            brace_reg  <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            upper_reg  <= upper_next;
            lower_reg  <= lower_next;
            failed_reg <= failed_next;
            start_reg  <= start_next;
            brace_reg  <= brace_next;
        end
    end

endmodule

[rtl/core/uuid_text_parser.sv]
// A last-character beat waits in the input register until the result register
// is free. Throughput: one character beat per cycle unless a result beat is
// blocked; set by the combinational decode and shift between the two registers.
// Reset: rst_n asynchronous, active low; clears all text state, brace and
// failure flags, and both pipeline valids.
`timescale 1ns / 1ps

module uuid_text_parser
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                character,
    input  logic                      is_last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      parsed_ok,
    output logic [uutp_pkg::HALF_W-1:0] id_high,
    output logic [uutp_pkg::HALF_W-1:0] id_low
);
    import uutp_pkg::*;

    logic               s1_valid_reg, s1_valid_next;
    logic [7:0]         s1_char_reg;
    logic               s1_last_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;

    logic               accept;
    logic               out_free;
    logic               s1_go;
    char_class_t        cls;
    result_t            result;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;

    uutp_hex_dec u_dec
    (
        .character (s1_char_reg),
        .cls       (cls)
    );

    uutp_accum u_accum
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (s1_go),
        .is_last (s1_last_reg),
        .cls     (cls),
        .result  (result)
    );

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        out_valid_next = out_valid_reg;
        if (s1_go && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_char_reg <= character;
            s1_last_reg <= is_last;
        end
        if (s1_go && s1_last_reg)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign parsed_ok = out_reg.ok;
    assign id_high   = out_reg.hi;
    assign id_low    = out_reg.lo;

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.ok |-> (out_reg.hi == '0) && (out_reg.lo == '0))
        else $error("failed result carries nonzero identifier");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> s1_valid_reg && $stable(s1_char_reg) && $stable(s1_last_reg))
        else $error("held character lost while stalled");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_last_reg |=> out_valid_reg)
        else $error("last character did not produce a result beat");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_last_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

endmodule

[tb/tb_uuid_text_parser.sv]
`timescale 1ns / 1ps

module tb_uuid_text_parser;

    import uutp_pkg::*;

    localparam int LATENCY      = 2;
    localparam int HALF_DIGITS  = 16;
    localparam int RANDOM_CHARS = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [7:0]          character  = 8'h00;
    logic                is_last    = 1'b0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic                parsed_ok;
    logic [HALF_W-1:0]   id_high;
    logic [HALF_W-1:0]   id_low;

    // predictor state for the text in flight
    logic [DIGIT_W-1:0]  txt_digits   = '0;
    logic [HALF_W-1:0]   txt_hi       = '0;
    logic [HALF_W-1:0]   txt_lo       = '0;
    logic                txt_failed   = 1'b0;
    logic                txt_at_start = 1'b1;
    logic                txt_brace    = 1'b0;

    result_t             pending_ids[$];
    logic [7:0]          text_buf[$];

    int                  mismatches  = 0;
    int                  cycles      = 0;
    int                  burst_left  = 0;
    int                  sent_chars  = 0;
    int                  stall_mode  = 0;
    int                  stall_left  = 0;
    int                  stall_run   = 0;

    uuid_text_parser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .character (character),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .parsed_ok (parsed_ok),
        .id_high   (id_high),
        .id_low    (id_low)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'h00;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            d = ch - CH_0;
            return {1'b1, d[3:0]};
        end
        if (ch >= CH_LA && ch <= CH_LF)
        begin
            d = ch - CH_LA + {4'd0, NIB_TEN};
            return {1'b1, d[3:0]};
        end
        if (ch >= CH_UA && ch <= CH_UF)
        begin
            d = ch - CH_UA + {4'd0, NIB_TEN};
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    task automatic parse_char(input logic [7:0] ch, input logic last);
        logic     first;
        logic [4:0] hv;
        result_t  res;
        first = txt_at_start;
        txt_at_start = 1'b0;
        hv = hex_value(ch);
        if (first && !last && ch == CH_OPEN)
            txt_brace = 1'b1;
        else if (last && ch == CH_CLOSE && txt_brace)
            ;
        else if (ch == CH_HYPHEN)
            ;
        else if (!hv[4])
            txt_failed = 1'b1;
        else if (txt_digits >= DIGITS_NEEDED)
            txt_failed = 1'b1;
        else
        begin
            if (txt_digits < HALF_DIGITS)
                txt_hi = {txt_hi[HALF_W-5:0], hv[3:0]};
            else
                txt_lo = {txt_lo[HALF_W-5:0], hv[3:0]};
            txt_digits = txt_digits + 1'b1;
        end
        if (last)
        begin
            res.ok = !txt_failed && txt_digits == DIGITS_NEEDED;
            if (txt_brace && ch != CH_CLOSE)
                res.ok = 1'b0;
            res.hi = res.ok ? txt_hi : '0;
            res.lo = res.ok ? txt_lo : '0;
            pending_ids.insert(pending_ids.size(), res);
            txt_digits   = '0;
            txt_hi       = '0;
            txt_lo       = '0;
            txt_failed   = 1'b0;
            txt_at_start = 1'b1;
            txt_brace    = 1'b0;
        end
    endtask

    // called in the time step of a rising edge, returns in the step of the accepting edge
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        in_valid  <= 1'b1;
        character <= ch;
        is_last   <= last;
        parse_char(ch, last);
        sent_chars = sent_chars + 1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_ids.size() != 0);
    endtask

    function automatic logic [7:0] rand_hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 8'd10)
            return CH_0 + v;
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + v - {4'd0, NIB_TEN};
    endfunction

    task automatic load_str(input string s);
        int i;
        text_buf.delete();
        for (i = 0; i < s.len(); i++)
            text_buf.insert(text_buf.size(), s[i]);
    endtask

    // hyphens: 0 none, 1 canonical 8-4-4-4-12, 2 scattered
    task automatic make_uuid(input logic braces, input int hyphens, input int digits);
        int i;
        text_buf.delete();
        if (braces)
            text_buf.insert(text_buf.size(), CH_OPEN);
        for (i = 0; i < digits; i++)
        begin
            if (hyphens == 1 && (i == 8 || i == 12 || i == 16 || i == 20))
                text_buf.insert(text_buf.size(), CH_HYPHEN);
            if (hyphens == 2 && $urandom_range(0, 5) == 0)
                text_buf.insert(text_buf.size(), CH_HYPHEN);
            text_buf.insert(text_buf.size(), rand_hex_char());
        end
        if (hyphens == 2 && $urandom_range(0, 3) == 0)
            text_buf.insert(text_buf.size(), CH_HYPHEN);
        if (braces)
            text_buf.insert(text_buf.size(), CH_CLOSE);
    endtask

    task automatic mutate_text();
        int pos;
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 5))
            0: text_buf[pos] = 8'($urandom_range(0, 255));
            1: if (text_buf.size() > 1) text_buf.delete(pos);
            2: text_buf.insert(pos, rand_hex_char());
            3: text_buf.insert(pos, $urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
            4: text_buf[text_buf.size() - 1] = 8'($urandom_range(0, 255));
            default: text_buf.insert(pos, CH_HYPHEN);
        endcase
    endtask

    task automatic make_noise();
        int n;
        int i;
        text_buf.delete();
        n = $urandom_range(1, 40);
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
                1: text_buf.insert(text_buf.size(), CH_HYPHEN);
                default: text_buf.insert(text_buf.size(), rand_hex_char());
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_ids.size() == 0)
            begin
                $error("unexpected result beat: parsed_ok=%0d id_high=%h id_low=%h",
                       parsed_ok, id_high, id_low);
                mismatches = mismatches + 1;
            end
            else
            begin
                if (parsed_ok !== pending_ids[0].ok)
                begin
                    $error("parsed_ok: expected %0d, actual %0d", pending_ids[0].ok, parsed_ok);
                    mismatches = mismatches + 1;
                end
                if (id_high !== pending_ids[0].hi)
                begin
                    $error("id_high: expected %h, actual %h", pending_ids[0].hi, id_high);
                    mismatches = mismatches + 1;
                end
                if (id_low !== pending_ids[0].lo)
                begin
                    $error("id_low: expected %h, actual %h", pending_ids[0].lo, id_low);
                    mismatches = mismatches + 1;
                end
                void'(pending_ids.pop_front());
            end
        end
        // receiver: free-flowing, random, alternating stall and flow runs, mostly stalled
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= $urandom_range(0, 1);
            2:
            begin
                if (stall_run == 0)
                begin
                    stall_run <= $urandom_range(1, 12);
                    out_stall <= ~out_stall;
                end
                else
                    stall_run <= stall_run - 1;
            end
            default: out_stall <= ($urandom_range(0, 4) != 0);
        endcase
    end

    task automatic test_canonical();
        load_str("00000000-0000-0000-0000-000000000000");
        send_text();
        load_str("FFFFFFFF-FFFF-FFFF-FFFF-FFFFFFFFFFFF");
        send_text();
        load_str("ffffffffffffffffffffffffffffffff");
        send_text();
        load_str("0123456789abcdefABCDEF0123456789");
        send_text();
        load_str("-01234567-89aB-cDeF--0123-456789abcdef-");
        send_text();
    endtask

    task automatic test_braces();
        load_str("{12345678-9abc-def0-1234-56789ABCDEF0}");
        send_text();
        load_str("{");
        send_text();
        load_str("{}");
        send_text();
        load_str("}");
        send_text();
        load_str("0{123456789abcdef0123456789abcdef}");
        send_text();
        load_str("{0123456789abcdef0123456789abcdef");
        send_text();
        load_str("0123456789abcdef0123456789abcdef}");
        send_text();
        load_str("0123}456789abcdef0123456789abcdef");
        send_text();
        load_str("{{0123456789abcdef0123456789abcdef}");
        send_text();
        load_str("{-0123456789abcdef0123456789abcdef-}");
        send_text();
    endtask

    task automatic test_digit_count();
        make_uuid(1'b0, 1, 31);
        send_text();
        make_uuid(1'b0, 1, 33);
        send_text();
        make_uuid(1'b1, 0, 64);
        send_text();
        load_str("a");
        send_text();
        load_str("---");
        send_text();
    endtask

    task automatic test_bad_chars();
        logic [7:0] bad[$];
        int i;
        bad = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF, 8'h20};
        for (i = 0; i < bad.size(); i++)
        begin
            make_uuid(1'b0, 1, 32);
            text_buf[$urandom_range(0, text_buf.size() - 1)] = bad[i];
            send_text();
        end
        make_uuid(1'b0, 0, 32);
        text_buf.insert(text_buf.size(), 8'h67);
        send_text();
    endtask

    task automatic test_random();
        int start;
        int sel;
        logic drained;
        start = sent_chars;
        drained = 1'b0;
        while (sent_chars - start < RANDOM_CHARS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                make_uuid($urandom_range(0, 3) == 0, $urandom_range(0, 2), 32);
            else if (sel < 85)
            begin
                make_uuid($urandom_range(0, 3) == 0, $urandom_range(0, 2), 32);
                mutate_text();
            end
            else
                make_noise();
            send_text();
            if (!drained && sent_chars - start >= RANDOM_CHARS / 2)
            begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_canonical();
        test_braces();
        test_digit_count();
        test_bad_chars();
        test_random();
        in_valid <= 1'b0;
        while (pending_ids.size() != 0)
            @(posedge clk);
        repeat (LATENCY * 8) @(posedge clk);
        if (pending_ids.size() != 0)
        begin
            $error("%0d results never arrived", pending_ids.size());
            mismatches = mismatches + 1;
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/uutp_pkg.sv
rtl/core/uutp_hex_dec.sv
rtl/core/uutp_accum.sv
rtl/core/uuid_text_parser.sv
tb/tb_uuid_text_parser.sv
